>>> design/ddo_pkg.sv
package ddo_pkg;

    // field widths fixed by the interface
    localparam int DIST_BITS     = 24;
    localparam int GAIN_BITS     = 24;

    // sizing of the pose and the sine table
    localparam int ANGLE_BITS       = 16;
    localparam int POSITION_BITS    = 32;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int QUAD_BITS  = ANGLE_BITS - 2;
    localparam int TAB_IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int TAB_ENT_W  = 16;
    localparam int SINE_W     = TAB_ENT_W + 1;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(4557100);

    // fixed point of the update
    localparam int TRIG_SHIFT = 16;
    localparam int GAIN_SHIFT = 24;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // taylor series divisors (2k)(2k+1)
    localparam logic [63:0] SERIES_DIV [0:6] = '{64'd1, 64'd6, 64'd20, 64'd42,
                                                 64'd72, 64'd110, 64'd156};

    typedef logic [TAB_ENT_W-1:0] t_sine_tab [0:SINE_TABLE_DEPTH];

    typedef struct packed {
        logic signed [DIST_BITS-1:0] left_dist;
        logic signed [DIST_BITS-1:0] right_dist;
    } t_odo_in;

    typedef struct packed {
        logic signed [POSITION_BITS-1:0] x_out;
        logic signed [POSITION_BITS-1:0] y_out;
        logic        [ANGLE_BITS-1:0]    heading_out;
    } t_odo_out;

    typedef struct packed {
        logic signed [SINE_W-1:0] sin_val;
        logic signed [SINE_W-1:0] cos_val;
    } t_trig;

    // quarter-wave sine in unsigned q1.15, built at elaboration
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab          tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int k = 1; k <= 6; k++) begin
                term = ((term * x2) >> 30) / SERIES_DIV[k];
                if (k % 2 == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            tab[i] = TAB_ENT_W'((unsigned'(sum) + 64'd16384) >> 15);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

>>> design/ddo_trig.sv
module ddo_trig
    import ddo_pkg::*;
(
    input  logic [ANGLE_BITS-1:0] i_heading,
    output t_trig                 o_trig
);

    localparam int J_W = QUAD_BITS + TAB_IDX_W;

    function automatic logic signed [SINE_W-1:0] sine_of(logic [ANGLE_BITS-1:0] a);
        logic [1:0]              q;
        logic [QUAD_BITS-1:0]    p;
        logic [J_W-1:0]          jw;
        logic [TAB_IDX_W-1:0]    j;
        logic signed [SINE_W-1:0] v;
        q  = a[ANGLE_BITS-1 -: 2];
        p  = a[QUAD_BITS-1:0];
        jw = (J_W'(p) * J_W'(SINE_TABLE_DEPTH)) >> QUAD_BITS;
        j  = jw[TAB_IDX_W-1:0];
        if (q[0]) begin
            v = signed'(SINE_W'(SINE_TAB[TAB_IDX_W'(SINE_TABLE_DEPTH) - j]));
        end else begin
            v = signed'(SINE_W'(SINE_TAB[j]));
        end
        return q[1] ? -v : v;
    endfunction

    logic [ANGLE_BITS-1:0] cos_angle;

    // cosine is the sine a quarter turn on
    assign cos_angle = i_heading + (ANGLE_BITS'(1) << QUAD_BITS);

    assign o_trig.sin_val = sine_of(i_heading);
    assign o_trig.cos_val = sine_of(cos_angle);

endmodule

>>> design/differential_drive_odometry_unit.sv
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_stall      i_in_word   (t_odo_in)
// out       output     o_out_valid / i_out_stall    o_out_word  (t_odo_out)
// cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_data  (heading gain)
//
// one word per clock sustained while the output is not stalled; a word is held in the
// input register and its pose is then written to the output register
// the loop that sets the rate: heading -> sine table -> multiply -> pose add
// synchronous active-low reset clears the pose and both valid flags and reloads
// the default gain
// a stall at the output holds the result; the input register still takes a word
// while it is empty, or while the output register is free or being drained the
// same cycle
module differential_drive_odometry_unit
    import ddo_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_odo_in              i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_odo_out             o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [GAIN_BITS-1:0] i_cfg_data
);

    localparam int SUM_W   = DIST_BITS + 1;
    localparam int TMUL_W  = SUM_W + SINE_W;
    localparam int GMUL_W  = SUM_W + GAIN_BITS + 1;

    // input register
    logic                  r_in_valid;
    t_odo_in               r_in;

    // pose state and gain
    logic signed [POSITION_BITS-1:0] r_x_pos;
    logic signed [POSITION_BITS-1:0] r_y_pos;
    logic        [ANGLE_BITS-1:0]    r_heading;
    logic        [GAIN_BITS-1:0]     r_gain;

    // result register
    logic                  r_out_valid;
    t_odo_out              r_out;

    logic                  advance;
    logic                  in_take;
    logic                  step;
    t_trig                 trig;

    logic signed [SUM_W-1:0]   wheel_sum;
    logic signed [SUM_W-1:0]   wheel_diff;
    logic signed [TMUL_W-1:0]  dx_prod;
    logic signed [TMUL_W-1:0]  dy_prod;
    logic signed [GMUL_W-1:0]  dh_prod;
    logic signed [TMUL_W-1:0]  dx_rnd;
    logic signed [TMUL_W-1:0]  dy_rnd;
    logic signed [GMUL_W-1:0]  dh_rnd;

    logic signed [POSITION_BITS-1:0] n_x_pos;
    logic signed [POSITION_BITS-1:0] n_y_pos;
    logic        [ANGLE_BITS-1:0]    n_heading;

    // output register free or emptied this cycle
    assign advance = !r_out_valid || !i_out_stall;
    assign step    = r_in_valid && advance;
    assign in_take = i_in_valid && !o_in_stall;

    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // sine and cosine of the old heading
    ddo_trig u_trig (
        .i_heading (r_heading),
        .o_trig    (trig)
    );

    // centre distance is half the sum; the halving sits in the extra shift bit
    assign wheel_sum  = SUM_W'(r_in.left_dist) + SUM_W'(r_in.right_dist);
    assign wheel_diff = SUM_W'(r_in.right_dist) - SUM_W'(r_in.left_dist);

    assign dx_prod = TMUL_W'(wheel_sum) * TMUL_W'(trig.cos_val);
    assign dy_prod = TMUL_W'(wheel_sum) * TMUL_W'(trig.sin_val);
    assign dh_prod = GMUL_W'(wheel_diff) * signed'(GMUL_W'(r_gain));

    // round half up, then arithmetic shift
    assign dx_rnd = (dx_prod + TMUL_W'(2 ** (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
    assign dy_rnd = (dy_prod + TMUL_W'(2 ** (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
    assign dh_rnd = (dh_prod + GMUL_W'(2 ** (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;

    // positions and heading wrap
    assign n_x_pos   = r_x_pos + POSITION_BITS'(dx_rnd);
    assign n_y_pos   = r_y_pos + POSITION_BITS'(dy_rnd);
    assign n_heading = r_heading + ANGLE_BITS'(dh_rnd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_x_pos     <= '0;
            r_y_pos     <= '0;
            r_heading   <= '0;
            r_gain      <= GAIN_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_gain <= i_cfg_data;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_x_pos   <= n_x_pos;
                r_y_pos   <= n_y_pos;
                r_heading <= n_heading;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_word;
        end
        if (step) begin
            r_out.x_out       <= n_x_pos;
            r_out.y_out       <= n_y_pos;
            r_out.heading_out <= n_heading;
        end
    end

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // the result shown is the pose just stored
    a_pose_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> (o_out_word.heading_out == r_heading) && (o_out_word.x_out == r_x_pos)
                 && (o_out_word.y_out == r_y_pos))
        else $error("result differs from pose state");

    // pose frozen while the result waits
    a_pose_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(r_heading) && $stable(r_x_pos))
        else $error("pose moved under output stall");

    // input stall only with both registers full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with room free");

endmodule

>>> tb/sv/tb_differential_drive_odometry_unit.sv
module tb_differential_drive_odometry_unit import ddo_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    // run shape
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_PER_PHASE = 35;
    localparam int MARATHON_STEPS   = 260;
    localparam int MAX_REPORTS      = 10;

    // wheel distance limits and handy moves
    localparam int DIST_MAX     = (1 << (DIST_BITS - 1)) - 1;
    localparam int DIST_MIN     = -(1 << (DIST_BITS - 1));
    localparam int QUARTER_HALF = 16384;  // +-this on the wheels turns 90 degrees at gain 0.5
    localparam int STRAIGHT_RUN = 25600;  // 100 mm

    localparam logic [GAIN_BITS-1:0] GAIN_HALF = 24'h80_0000;
    localparam logic [GAIN_BITS-1:0] GAIN_ZERO = 24'h00_0000;
    localparam logic [GAIN_BITS-1:0] GAIN_FULL = 24'hFF_FFFF;
    localparam logic [GAIN_BITS-1:0] GAIN_ONE  = 24'h00_0001;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_odo_in              i_in_word   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_odo_out             o_out_word;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [GAIN_BITS-1:0] i_cfg_data  = '0;

    differential_drive_odometry_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // pose tracker of our own: quarter-wave sine, pose and current gain
    int unsigned              quarter_sine [0:SINE_TABLE_DEPTH];
    logic [POSITION_BITS-1:0] pose_x   = '0;
    logic [POSITION_BITS-1:0] pose_y   = '0;
    logic [ANGLE_BITS-1:0]    pose_hdg = '0;
    logic [GAIN_BITS-1:0]     gain_now = GAIN_RESET;
    logic [3:0]               quadrants_seen = '0;

    t_odo_in  step_q [$];  // wheel steps still to be offered
    t_odo_out pose_q [$];  // poses owed by the block, oldest first

    bit idle_on       = 1'b1;
    int long_hold_ask = 0;
    int steps_sent    = 0;
    int poses_checked = 0;
    int pose_errs     = 0;
    int gain_writes   = 0;

    // signed sine of a binary angle, q1.15
    function automatic longint trig_of(logic [ANGLE_BITS-1:0] ang);
        longint idx;
        longint mag;
        idx = (longint'(ang[QUAD_BITS-1:0]) * SINE_TABLE_DEPTH) >>> QUAD_BITS;
        // odd quadrants read the table backwards
        mag = ang[QUAD_BITS] ? longint'(quarter_sine[SINE_TABLE_DEPTH - idx])
                             : longint'(quarter_sine[idx]);
        // upper half of the turn is negative
        return ang[ANGLE_BITS-1] ? -mag : mag;
    endfunction

    // one dead-reckoning update; trig uses the heading from before the step
    function automatic t_odo_out advance_pose(t_odo_in w);
        longint   wsum;
        longint   wdiff;
        longint   dx;
        longint   dy;
        longint   dh;
        t_odo_out p;
        wsum  = longint'($signed(w.left_dist)) + longint'($signed(w.right_dist));
        wdiff = longint'($signed(w.right_dist)) - longint'($signed(w.left_dist));
        quadrants_seen[pose_hdg[ANGLE_BITS-1 -: 2]] = 1'b1;
        // the extra bit of shift halves the wheel sum; all rounding is half up
        dx = (wsum * trig_of(pose_hdg + (1 << QUAD_BITS)) + (64'sd1 <<< (TRIG_SHIFT - 1)))
             >>> TRIG_SHIFT;
        dy = (wsum * trig_of(pose_hdg) + (64'sd1 <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
        dh = (wdiff * longint'(gain_now) + (64'sd1 <<< (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
        // no saturation: pose and heading simply wrap
        pose_x   = pose_x + dx[POSITION_BITS-1:0];
        pose_y   = pose_y + dy[POSITION_BITS-1:0];
        pose_hdg = pose_hdg + dh[ANGLE_BITS-1:0];
        p.x_out       = pose_x;
        p.y_out       = pose_y;
        p.heading_out = pose_hdg;
        return p;
    endfunction

    function automatic void push_step(int left, int right);
        t_odo_in w;
        w.left_dist  = DIST_BITS'(left);
        w.right_dist = DIST_BITS'(right);
        step_q.push_back(w);
    endfunction

    function automatic int extreme_dist();
        case ($urandom_range(0, 4))
            0:       return DIST_MIN;
            1:       return DIST_MAX;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    // gain changes only while nothing is in flight
    task automatic write_gain(logic [GAIN_BITS-1:0] gain);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= gain;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        gain_now = gain;
        gain_writes++;
        @(negedge i_clk);
    endtask

    // sender pauses here until every owed pose has come back
    task automatic wait_drained();
        do @(negedge i_clk); while (step_q.size() != 0 || i_in_valid || pose_q.size() != 0);
    endtask

    // input driver: hold a word until taken, otherwise offer the next one or idle
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_odo_in nxt_word;
        logic    nxt_valid;
        nxt_word  = i_in_word;
        nxt_valid = i_in_valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                // word taken at this edge: work out the pose it must produce
                pose_q.push_back(advance_pose(i_in_word));
                steps_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (step_q.size() != 0) begin
                    nxt_word  = step_q.pop_front();
                    nxt_valid = 1'b1;
                    // a burst of idle cycles after this word, now and then
                    if (idle_on && $urandom_range(0, 4) == 0) begin
                        gap_left = $urandom_range(1, 7);
                    end
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_in_word  <= nxt_word;
    end

    // output back-pressure: short random bursts, or one long hold when asked
    int stall_left  = 0;
    int holds_taken = 0;
    always @(posedge i_clk) begin
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (holds_taken != long_hold_ask) begin
            holds_taken = long_hold_ask;
            stall_left  = LONG_HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            nxt_stall = 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            nxt_stall  = 1'b1;
        end
        i_out_stall <= nxt_stall;
    end

    // pose checker: each word out against the oldest owed pose
    always @(posedge i_clk) begin
        t_odo_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pose_q.size() == 0) begin
                pose_errs++;
                if (pose_errs <= MAX_REPORTS) begin
                    $display("%0t: pose word with none owed: x %0d y %0d heading %0d",
                             $realtime, o_out_word.x_out, o_out_word.y_out,
                             o_out_word.heading_out);
                end
            end else begin
                want = pose_q.pop_front();
                poses_checked++;
                if (want.x_out !== o_out_word.x_out || want.y_out !== o_out_word.y_out ||
                    want.heading_out !== o_out_word.heading_out) begin
                    pose_errs++;
                    if (pose_errs <= MAX_REPORTS) begin
                        $display("%0t: pose %0d wrong: x exp %0d got %0d, y exp %0d got %0d, heading exp %0d got %0d",
                                 $realtime, poses_checked, want.x_out, o_out_word.x_out,
                                 want.y_out, o_out_word.y_out, want.heading_out,
                                 o_out_word.heading_out);
                    end
                end
            end
        end
    end

    // watchdog: too long without any handshake means the block has hung
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d poses still owed",
                     $realtime, quiet_cycles, pose_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        longint unsigned      ang;
        longint unsigned      ang2;
        longint unsigned      term;
        longint               acc;
        int                   back;
        int                   base;
        logic [GAIN_BITS-1:0] phase_gain [5];

        // quarter-wave sine in q1.15 from a seven-term taylor series in q30
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            ang  = i;
            ang  = (ang * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            ang2 = (ang * ang) >> 30;
            term = ang;
            acc  = ang;
            for (int k = 1; k <= 6; k++) begin
                term = ((term * ang2) >> 30) / ((2 * k) * (2 * k + 1));
                acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) begin
                acc = 0;
            end
            quarter_sine[i] = (acc + 16384) >> 15;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // wheel extremes at the gain left by reset
        push_step(0, 0);
        push_step(DIST_MAX, DIST_MAX);
        push_step(DIST_MIN, DIST_MIN);
        push_step(DIST_MAX, DIST_MIN);
        push_step(DIST_MIN, DIST_MAX);
        push_step(-1, 1);
        push_step(1, -1);
        wait_drained();

        // gain of one half turns half the wheel difference into heading
        write_gain(GAIN_HALF);
        // spin back to heading zero from wherever the extremes left it
        back = -int'($signed(pose_hdg));
        push_step(0, 2 * back);
        // quarter turns: straight moves sitting exactly on each quadrant boundary
        for (int q = 0; q < 4; q++) begin
            push_step(-QUARTER_HALF, QUARTER_HALF);
            push_step(STRAIGHT_RUN, STRAIGHT_RUN);
        end
        push_step(STRAIGHT_RUN, STRAIGHT_RUN);
        push_step(QUARTER_HALF, -QUARTER_HALF);
        push_step(-QUARTER_HALF, QUARTER_HALF);
        push_step(-2 * QUARTER_HALF, 2 * QUARTER_HALF);
        push_step(-2 * QUARTER_HALF, 2 * QUARTER_HALF);
        wait_drained();

        // zero gain: heading frozen at zero, long straight run takes x past the wrap
        write_gain(GAIN_ZERO);
        for (int n = 0; n < MARATHON_STEPS; n++) begin
            push_step(DIST_MAX, DIST_MAX);
        end
        wait_drained();

        // random driving under several gains; the third and fifth phases run without idling
        phase_gain = '{GAIN_RESET, GAIN_FULL, GAIN_BITS'($urandom), GAIN_ONE,
                       GAIN_BITS'($urandom)};
        for (int ph = 0; ph < 5; ph++) begin
            write_gain(phase_gain[ph]);
            idle_on = (ph != 2 && ph != 4);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        // ordinary driving: wheels close together, gentle turns
                        base = $urandom_range(0, 8000) - 4000;
                        push_step(base + $urandom_range(0, 400) - 200,
                                  base + $urandom_range(0, 400) - 200);
                    end
                    6, 7: begin
                        push_step($urandom, $urandom);
                    end
                    default: begin
                        push_step(extreme_dist(), extreme_dist());
                    end
                endcase
            end
            if (ph == 1) begin
                // long hold at the output while the sender keeps offering
                repeat (3) @(negedge i_clk);
                long_hold_ask++;
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("odometry run: %0d wheel steps in, %0d poses checked, %0d gain writes",
                 steps_sent, poses_checked, gain_writes);
        $display("heading quadrants visited %b, zero and full-scale gain included",
                 quadrants_seen);
        if (pose_errs == 0 && pose_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
